>>> sv/cba_pkg.sv
package cba_pkg;

  localparam int NUM_BLOCKS  = 1024;
  localparam int BLOCK_BYTES = 1024;

  localparam int IDX_W   = 11;
  localparam int TAG_W   = 14;
  localparam int OFF_W   = 20;
  localparam int ADDR_W  = $clog2(NUM_BLOCKS);

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_OOM = 2'd1,
    STAT_BAD = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISP,
    ST_PAR,
    ST_NB,
    ST_TAIL,
    ST_PWR,
    ST_FREE
  } state_e;

  // one word per block: live flag, owner, chain tail and next link
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] owner;
    logic [IDX_W-1:0] tail;
    logic [IDX_W-1:0] next;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    kind_e            kind;
    logic [IDX_W-1:0] parent;
    logic [TAG_W-1:0] tag;
    logic [IDX_W-1:0] head;
  } item_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] blk;
    logic [OFF_W-1:0] off;
    status_e          status;
    logic [IDX_W-1:0] in_use;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic in_range(input logic [IDX_W-1:0] n);
    return (n != '0) && (n <= IDX_W'(NUM_BLOCKS));
  endfunction

  function automatic logic [ADDR_W-1:0] blk_addr(input logic [IDX_W-1:0] n);
    logic [IDX_W-1:0] d;
    d = n - IDX_W'(1);
    return d[ADDR_W-1:0];
  endfunction

  function automatic logic [OFF_W-1:0] blk_offset(input logic [IDX_W-1:0] n);
    logic [IDX_W-1:0]       d;
    logic [IDX_W+OFF_W-1:0] p;
    d = n - IDX_W'(1);
    p = (IDX_W+OFF_W)'(d) * (IDX_W+OFF_W)'(BLOCK_BYTES);
    return (n == '0) ? '0 : p[OFF_W-1:0];
  endfunction

endpackage

>>> sv/chained_block_allocator_top.sv
// Channel   | Dir | Signals                  | Item contents (lowest bit up)
// s_axis    | in  | tvalid/tready/tdata/tuser| tuser: kind; tdata: parent_index,
//           |     |                          |   owner_tag, chain_head
// m_axis    | out | tvalid/tready/tdata      | tdata: block_index, byte_offset,
//           |     |                          |   status, blocks_in_use
//
// One item at a time; the single RAM read port sets the pace. Allocate reads the
// parent (if any), then the free-list head, then the parent's tail when it names another
// block; a live tail is linked to the new block, a stale one is bypassed. Free walks a
// chain one block per cycle while the output register is free, and stops at a link out
// of range, a self link or a link to a free block; a bad or unallocated parent or chain
// head is rejected. After reset a clearing pass over all NUM_BLOCKS (1024) entries builds
// the free list; no item is taken meanwhile.
// A held result waits in the output register; s_axis still takes the next item,
// whose processing pauses until the register is free.
module chained_block_allocator_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // parent_index[10:0], owner_tag[24:11], chain_head[35:25], zero pad
  input  logic [cba_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // kind
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // block_index[10:0], byte_offset[30:11], status[32:31], blocks_in_use[43:33], zero pad
  output logic [cba_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);

  cba_pkg::item_t            item;
  cba_pkg::res_t             res;
  cba_pkg::mem_req_t         mem_req;
  logic [cba_pkg::ENTRY_W-1:0] mem_rdata;
  logic                      slot_free;

  logic                      out_valid_q, out_valid_d;
  cba_pkg::res_t             out_q, out_d;

  // unpack the incoming item
  assign item.kind   = cba_pkg::kind_e'(s_axis_tuser_i);
  assign item.parent = s_axis_tdata_i[10:0];
  assign item.tag    = s_axis_tdata_i[24:11];
  assign item.head   = s_axis_tdata_i[35:25];

  // control pauses while a result is held and not being taken
  assign slot_free = !out_valid_q || m_axis_tready_i;

  cba_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid_i),
    .item_ready_o (s_axis_tready_o),
    .item_i       (item),
    .go_i         (slot_free),
    .res_o        (res),
    .mem_o        (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

  // block table: live flag, owner, chain tail, next link
  cba_ram #(
    .WIDTH (cba_pkg::ENTRY_W),
    .DEPTH (cba_pkg::NUM_BLOCKS)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (res.valid) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_q.in_use, out_q.status, out_q.off, out_q.blk};

endmodule

>>> sv/cba_ram.sv
module cba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/cba_ctrl.sv
module cba_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         item_valid_i,
  output logic                         item_ready_o,
  input  cba_pkg::item_t               item_i,
  input  logic                         go_i,
  output cba_pkg::res_t                res_o,
  output cba_pkg::mem_req_t            mem_o,
  input  logic [cba_pkg::ENTRY_W-1:0]  mem_rdata_i
);

  cba_pkg::state_e                state_q, state_d;
  cba_pkg::item_t                 item_q, item_d;
  cba_pkg::entry_t                par_q, par_d;
  cba_pkg::entry_t                rd;
  cba_pkg::entry_t                upd;
  logic [cba_pkg::IDX_W-1:0]      free_head_q, free_head_d;
  logic [cba_pkg::IDX_W-1:0]      use_cnt_q, use_cnt_d;
  logic [cba_pkg::IDX_W-1:0]      cur_q, cur_d;
  logic [cba_pkg::IDX_W-1:0]      nb_q, nb_d;
  logic [cba_pkg::ADDR_W-1:0]     init_cnt_q, init_cnt_d;
  logic                           first_q, first_d;
  logic                           link_par_q, link_par_d;
  logic                           fh_ok;
  logic [cba_pkg::IDX_W-1:0]      tail_blk;
  logic [cba_pkg::IDX_W-1:0]      nxt;

  assign rd       = cba_pkg::entry_t'(mem_rdata_i);
  assign fh_ok    = cba_pkg::in_range(free_head_q);
  assign tail_blk = par_q.tail;
  assign nxt      = rd.next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cba_pkg::ST_INIT;
      init_cnt_q  <= '0;
      free_head_q <= cba_pkg::IDX_W'(1);
      use_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      init_cnt_q  <= init_cnt_d;
      free_head_q <= free_head_d;
      use_cnt_q   <= use_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    par_q      <= par_d;
    cur_q      <= cur_d;
    nb_q       <= nb_d;
    first_q    <= first_d;
    link_par_q <= link_par_d;
  end

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    par_d        = par_q;
    cur_d        = cur_q;
    nb_d         = nb_q;
    first_d      = first_q;
    link_par_d   = link_par_q;
    init_cnt_d   = init_cnt_q;
    free_head_d  = free_head_q;
    use_cnt_d    = use_cnt_q;
    item_ready_o = 1'b0;
    mem_o        = '0;
    res_o        = '0;
    res_o.status = cba_pkg::STAT_OK;
    res_o.in_use = use_cnt_q;
    upd          = rd;

    unique case (state_q)
      cba_pkg::ST_INIT: begin
        mem_o.we          = 1'b1;
        mem_o.waddr       = init_cnt_q;
        mem_o.wdata       = '0;
        if (init_cnt_q == cba_pkg::ADDR_W'(cba_pkg::NUM_BLOCKS - 1)) begin
          mem_o.wdata.next = '0;
          state_d          = cba_pkg::ST_IDLE;
        end else begin
          mem_o.wdata.next = cba_pkg::IDX_W'(init_cnt_q) + cba_pkg::IDX_W'(2);
        end
        init_cnt_d = init_cnt_q + cba_pkg::ADDR_W'(1);
      end

      cba_pkg::ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          item_d  = item_i;
          state_d = cba_pkg::ST_DISP;
        end
      end

      cba_pkg::ST_DISP: begin
        if (go_i) begin
          if (item_q.kind == cba_pkg::KIND_ALLOC) begin
            if (item_q.parent != '0) begin
              if (!cba_pkg::in_range(item_q.parent)) begin
                res_o.valid  = 1'b1;
                res_o.status = cba_pkg::STAT_BAD;
                state_d      = cba_pkg::ST_IDLE;
              end else begin
                mem_o.re    = 1'b1;
                mem_o.raddr = cba_pkg::blk_addr(item_q.parent);
                state_d     = cba_pkg::ST_PAR;
              end
            end else if (fh_ok) begin
              mem_o.re    = 1'b1;
              mem_o.raddr = cba_pkg::blk_addr(free_head_q);
              state_d     = cba_pkg::ST_NB;
            end else begin
              res_o.valid  = 1'b1;
              res_o.status = cba_pkg::STAT_OOM;
              state_d      = cba_pkg::ST_IDLE;
            end
          end else if (cba_pkg::in_range(item_q.head)) begin
            mem_o.re    = 1'b1;
            mem_o.raddr = cba_pkg::blk_addr(item_q.head);
            cur_d       = item_q.head;
            first_d     = 1'b1;
            state_d     = cba_pkg::ST_FREE;
          end else begin
            res_o.valid  = 1'b1;
            res_o.status = cba_pkg::STAT_BAD;
            state_d      = cba_pkg::ST_IDLE;
          end
        end
      end

      cba_pkg::ST_PAR: begin
        if (go_i) begin
          par_d = rd;
          if (!rd.valid) begin
            res_o.valid  = 1'b1;
            res_o.status = cba_pkg::STAT_BAD;
            state_d      = cba_pkg::ST_IDLE;
          end else if (!fh_ok) begin
            res_o.valid  = 1'b1;
            res_o.status = cba_pkg::STAT_OOM;
            state_d      = cba_pkg::ST_IDLE;
          end else begin
            mem_o.re    = 1'b1;
            mem_o.raddr = cba_pkg::blk_addr(free_head_q);
            state_d     = cba_pkg::ST_NB;
          end
        end
      end

      cba_pkg::ST_NB: begin
        if (go_i) begin
          mem_o.we          = 1'b1;
          mem_o.waddr       = cba_pkg::blk_addr(free_head_q);
          mem_o.wdata.valid = 1'b1;
          mem_o.wdata.owner = item_q.tag;
          mem_o.wdata.tail  = '0;
          mem_o.wdata.next  = '0;
          free_head_d       = rd.next;
          use_cnt_d         = use_cnt_q + cba_pkg::IDX_W'(1);
          nb_d              = free_head_q;
          if (item_q.parent == '0) begin
            res_o.valid  = 1'b1;
            res_o.blk    = free_head_q;
            res_o.off    = cba_pkg::blk_offset(free_head_q);
            res_o.in_use = use_cnt_d;
            state_d      = cba_pkg::ST_IDLE;
          end else if (cba_pkg::in_range(tail_blk) && (tail_blk != free_head_q)) begin
            mem_o.re    = 1'b1;
            mem_o.raddr = cba_pkg::blk_addr(tail_blk);
            state_d     = cba_pkg::ST_TAIL;
          end else begin
            link_par_d = 1'b1;
            state_d    = cba_pkg::ST_PWR;
          end
        end
      end

      cba_pkg::ST_TAIL: begin
        if (go_i) begin
          mem_o.we = 1'b1;
          if (rd.valid) begin
            // live tail: hang the new block off it, parent keeps its link
            upd.next    = nb_q;
            mem_o.waddr = cba_pkg::blk_addr(tail_blk);
            mem_o.wdata = upd;
            link_par_d  = 1'b0;
            state_d     = cba_pkg::ST_PWR;
          end else begin
            // stale tail: parent links straight to the new block
            upd         = par_q;
            upd.next    = nb_q;
            upd.tail    = nb_q;
            mem_o.waddr = cba_pkg::blk_addr(item_q.parent);
            mem_o.wdata = upd;
            res_o.valid = 1'b1;
            res_o.blk   = nb_q;
            res_o.off   = cba_pkg::blk_offset(nb_q);
            state_d     = cba_pkg::ST_IDLE;
          end
        end
      end

      cba_pkg::ST_PWR: begin
        if (go_i) begin
          upd      = par_q;
          upd.tail = nb_q;
          if (link_par_q) begin
            upd.next = nb_q;
          end
          mem_o.we    = 1'b1;
          mem_o.waddr = cba_pkg::blk_addr(item_q.parent);
          mem_o.wdata = upd;
          res_o.valid = 1'b1;
          res_o.blk   = nb_q;
          res_o.off   = cba_pkg::blk_offset(nb_q);
          state_d     = cba_pkg::ST_IDLE;
        end
      end

      cba_pkg::ST_FREE: begin
        if (go_i) begin
          if (rd.valid) begin
            upd.valid   = 1'b0;
            upd.tail    = '0;
            upd.next    = free_head_q;
            mem_o.we    = 1'b1;
            mem_o.waddr = cba_pkg::blk_addr(cur_q);
            mem_o.wdata = upd;
            free_head_d = cur_q;
            use_cnt_d   = use_cnt_q - cba_pkg::IDX_W'(1);
            first_d     = 1'b0;
            // a self link would read stale data this cycle, so it ends the walk
            if (cba_pkg::in_range(nxt) && (nxt != cur_q)) begin
              mem_o.re    = 1'b1;
              mem_o.raddr = cba_pkg::blk_addr(nxt);
              cur_d       = nxt;
            end else begin
              res_o.valid  = 1'b1;
              res_o.in_use = use_cnt_d;
              state_d      = cba_pkg::ST_IDLE;
            end
          end else begin
            res_o.valid  = 1'b1;
            res_o.status = first_q ? cba_pkg::STAT_BAD : cba_pkg::STAT_OK;
            state_d      = cba_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_d = cba_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import cba_pkg::*;

  localparam int LIMIT      = 20000;  // cycles with no item moving on either side
  localparam int RAND_ITEMS = 1430;
  localparam int OOM_WANTED = 12;
  localparam int HOLD_AT    = 500;    // result count that starts the long receiver hold
  localparam int HOLD_LEN   = 300;

  localparam int MODE_MIX   = 0;
  localparam int MODE_FILL  = 1;
  localparam int MODE_DRAIN = 2;

  typedef struct packed {
    logic [IDX_W-1:0] blk;
    logic [OFF_W-1:0] off;
    status_e          st;
    logic [IDX_W-1:0] used;
  } alloc_result_t;

  // Tracks the pool exactly as the block should and holds the results still due.
  class pool_tracker;
    logic [IDX_W-1:0] link_of [NUM_BLOCKS];
    logic [IDX_W-1:0] tail_of [NUM_BLOCKS];
    bit               taken   [NUM_BLOCKS];
    logic [IDX_W-1:0] free_top;
    logic [IDX_W-1:0] used_count;
    alloc_result_t    due_results [$];
    int               errors;

    function new();
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        link_of[i] = (i + 1 < NUM_BLOCKS) ? IDX_W'(i + 2) : '0;
        tail_of[i] = '0;
        taken[i]   = 1'b0;
      end
      free_top   = IDX_W'(1);
      used_count = '0;
      errors     = 0;
    endfunction

    function bit is_live(logic [IDX_W-1:0] n);
      if (n == '0 || int'(n) > NUM_BLOCKS) return 1'b0;
      return taken[int'(n) - 1];
    endfunction

    // random allocated block, 0 if the pool is empty
    function logic [IDX_W-1:0] any_live();
      int k;
      if (used_count == '0) return '0;
      k = $urandom_range(int'(used_count) - 1);
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        if (taken[i]) begin
          if (k == 0) return IDX_W'(i + 1);
          k--;
        end
      end
      return '0;
    endfunction

    function alloc_result_t note_item(kind_e k, logic [IDX_W-1:0] parent,
                                      logic [IDX_W-1:0] head);
      alloc_result_t    r;
      logic [IDX_W-1:0] nb, t, cur, nxt;
      r.blk = '0;
      r.st  = STAT_OK;
      if (k == KIND_ALLOC) begin
        if (parent != '0 && !is_live(parent)) begin
          r.st = STAT_BAD;
        end else if (free_top == '0 || int'(free_top) > NUM_BLOCKS) begin
          r.st = STAT_OOM;
        end else begin
          nb       = free_top;
          free_top = link_of[int'(nb) - 1];
          taken[int'(nb) - 1]   = 1'b1;
          link_of[int'(nb) - 1] = '0;
          tail_of[int'(nb) - 1] = '0;
          if (parent != '0) begin
            t = tail_of[int'(parent) - 1];
            // a stale tail falls back to linking straight after the parent
            if (is_live(t) && t != nb) link_of[int'(t) - 1] = nb;
            else link_of[int'(parent) - 1] = nb;
            tail_of[int'(parent) - 1] = nb;
          end
          used_count = used_count + 1'b1;
          r.blk = nb;
        end
      end else if (!is_live(head)) begin
        r.st = STAT_BAD;
      end else begin
        // walk stops at the first link that is not a live block
        cur = head;
        while (is_live(cur)) begin
          nxt = link_of[int'(cur) - 1];
          taken[int'(cur) - 1]   = 1'b0;
          tail_of[int'(cur) - 1] = '0;
          link_of[int'(cur) - 1] = free_top;
          free_top   = cur;
          used_count = used_count - 1'b1;
          cur = nxt;
        end
      end
      r.used = used_count;
      r.off  = (r.blk == '0) ? '0 : OFF_W'((int'(r.blk) - 1) * BLOCK_BYTES);
      due_results.push_back(r);
      return r;
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      alloc_result_t want, got;
      got.blk  = d[IDX_W-1:0];
      got.off  = d[IDX_W +: OFF_W];
      got.st   = status_e'(d[IDX_W+OFF_W +: 2]);
      got.used = d[IDX_W+OFF_W+2 +: IDX_W];
      if (due_results.size() == 0) begin
        $display("%0t: result %h with nothing expected", $time, d);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.blk !== want.blk) begin
        $display("%0t: block_index expected %0d got %0d", $time, want.blk, got.blk);
        errors++;
      end
      if (got.off !== want.off) begin
        $display("%0t: byte_offset expected %0d got %0d", $time, want.off, got.off);
        errors++;
      end
      if (got.st !== want.st) begin
        $display("%0t: status expected %0d got %0d", $time, want.st, got.st);
        errors++;
      end
      if (got.used !== want.used) begin
        $display("%0t: blocks_in_use expected %0d got %0d", $time, want.used, got.used);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [IN_DATA_W-1:0]  s_data = '0;
  logic                  s_user = 1'b0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;

  bit                    calm = 1'b0;   // no idling on either side while set
  pool_tracker           pool = new();
  logic [IDX_W-1:0]      chain_heads [$];

  chained_block_allocator_top DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Offer one item, wait for the handshake, record it, then maybe idle.
  task automatic offer(input kind_e k, input logic [IDX_W-1:0] parent,
                       input logic [TAG_W-1:0] tag, input logic [IDX_W-1:0] head,
                       output alloc_result_t r);
    s_valid <= 1'b1;
    s_data  <= IN_DATA_W'({head, tag, parent});
    s_user  <= k;
    do @(posedge clk); while (!s_ready);
    r = pool.note_item(k, parent, head);
    while (!calm && $urandom_range(99) < 38) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // live chain head picked at random; dead entries are pruned on the way
  function automatic logic [IDX_W-1:0] pick_head();
    int i;
    while (chain_heads.size() != 0) begin
      i = $urandom_range(chain_heads.size() - 1);
      if (pool.is_live(chain_heads[i])) return chain_heads[i];
      chain_heads.delete(i);
    end
    return '0;
  endfunction

  task automatic random_item(input int mode, output alloc_result_t r);
    int               roll, pick, alloc_pct, free_pct;
    kind_e            k;
    logic [IDX_W-1:0] par, hd;
    logic [TAG_W-1:0] tag;
    alloc_pct = (mode == MODE_FILL) ? 95 : (mode == MODE_DRAIN) ? 30 : 55;
    free_pct  = (mode == MODE_FILL) ? 95 : 92;
    roll = $urandom_range(99);
    pick = $urandom_range(99);
    tag  = TAG_W'($urandom);
    par  = IDX_W'($urandom);    // unused fields carry noise
    hd   = IDX_W'($urandom);
    if (roll < alloc_pct) begin
      k = KIND_ALLOC;
      if (pick < 25) par = '0;
      else if (pick < 80) par = pick_head();
      else if (pick < 95) par = pool.any_live();   // usually a chain member
    end else if (roll < free_pct) begin
      k = KIND_FREE;
      if (pick < 70) hd = pick_head();
      else if (pick < 92) hd = pool.any_live();
      else hd = IDX_W'($urandom_range(NUM_BLOCKS));
    end else begin
      k = kind_e'($urandom_range(1));
    end
    offer(k, par, tag, hd, r);
    if (k == KIND_ALLOC && r.st == STAT_OK && par == '0) chain_heads.push_back(r.blk);
  endtask

  // Stimulus: directed walk through the corner cases, then a random run
  // that mixes, fills the pool past exhaustion, and drains it again.
  initial begin
    alloc_result_t    r;
    logic [IDX_W-1:0] a, b, c, d, f, x, y;
    int               n, ooms, mode;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // bad chain heads on an empty pool
    offer(KIND_FREE, '0, '0, '0, r);
    offer(KIND_FREE, 11'h7FF, 14'h3FFF, 11'd1, r);
    offer(KIND_FREE, '0, '0, 11'h7FF, r);
    offer(KIND_FREE, '0, '0, 11'd1025, r);
    // two new chains, then appends with and without a tail
    offer(KIND_ALLOC, '0, '0, 11'h7FF, r);            a = r.blk;
    offer(KIND_ALLOC, '0, 14'h3FFF, '0, r);           b = r.blk;
    offer(KIND_ALLOC, a, 14'h1555, '0, r);            c = r.blk;
    offer(KIND_ALLOC, a, 14'h2AAA, 11'h555, r);       d = r.blk;
    // bad parents: unallocated and out of range
    offer(KIND_ALLOC, 11'd1024, 14'h0001, '0, r);
    offer(KIND_ALLOC, 11'h7FF, 14'h2000, '0, r);
    offer(KIND_ALLOC, 11'd1025, '0, '0, r);
    // chain member as parent: its link is overwritten, the rest splits off
    offer(KIND_ALLOC, c, 14'h0F0F, '0, r);
    offer(KIND_FREE, 11'h2AA, '0, a, r);
    offer(KIND_FREE, '0, 14'h3FFF, d, r);
    // free from mid-chain leaves the head with a stale tail
    offer(KIND_ALLOC, b, 14'h00FF, '0, r);            f = r.blk;
    offer(KIND_ALLOC, b, 14'h3F00, '0, r);
    offer(KIND_FREE, '0, '0, f, r);
    offer(KIND_ALLOC, b, 14'h1234, '0, r);
    // broken chain: head links to a block already freed
    offer(KIND_ALLOC, '0, 14'h2345, '0, r);           x = r.blk;
    offer(KIND_ALLOC, x, 14'h3456, '0, r);            y = r.blk;
    offer(KIND_FREE, '0, '0, y, r);
    offer(KIND_FREE, '0, '0, x, r);
    offer(KIND_FREE, '0, '0, b, r);
    offer(KIND_FREE, '0, '0, b, r);   // already freed

    n    = 0;
    ooms = 0;
    while (n < RAND_ITEMS || ooms < OOM_WANTED) begin
      calm = (n >= 150 && n < 260);
      mode = (n < 200) ? MODE_MIX : (ooms < OOM_WANTED) ? MODE_FILL : MODE_DRAIN;
      random_item(mode, r);
      if (r.st == STAT_OOM) ooms++;
      n++;
    end
    calm = 1'b0;
    s_valid <= 1'b0;

    while (pool.due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pool.errors == 0 && pool.due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver: checks each result, stalls at random, and once holds off long
  // enough for the block to back up and drop s_axis_tready.
  initial begin
    int got_count, hold;
    got_count = 0;
    hold      = 0;
    forever begin
      @(posedge clk);
      if (m_valid && m_ready) begin
        pool.check_result(m_data);
        got_count++;
        if (got_count == HOLD_AT) hold = HOLD_LEN;
      end
      if (hold > 0) begin
        hold--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= calm || ($urandom_range(99) >= 38);
      end
    end
  end

  // Watchdog: too long with no item moving on either side ends the run.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < LIMIT) begin
      @(posedge clk);
      if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
sv/cba_pkg.sv
sv/cba_ram.sv
sv/cba_ctrl.sv
sv/chained_block_allocator_top.sv
test/tb.sv
